// ===== sv/eio_pkg.sv =====
// ----------------------------------------------------------------------------
// eio_pkg
// Shared types and constants for the ease-in/out interpolator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package eio_pkg;

  localparam int TIME_W    = 16;
  localparam int VAL_W     = 32;
  localparam int NUM_W     = 36;  // signed ratio operands
  localparam int Q_W       = 31;  // raw quotient bits
  localparam int F_W       = 31;  // Q1.30 fraction, holds 1.0
  localparam int DIV_STEPS = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [F_W-1:0] ONE30 = F_W'(1) << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_DURATION = 3'd0,
    REG_EASE_IN_TIME   = 3'd1,
    REG_EASE_OUT_TIME  = 3'd2,
    REG_START_VALUE    = 3'd3,
    REG_END_VALUE      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEG_ACCEL  = 3'd0,
    SEG_CRUISE = 3'd1,
    SEG_DECEL  = 3'd2,
    SEG_HERM   = 3'd3,
    SEG_LINEAR = 3'd4,
    SEG_FULL   = 3'd5
  } seg_t;

  // control that travels alongside the divider data
  typedef struct packed {
    logic valid;
    logic zero;
    logic one;
    logic herm;
  } eio_ctl_t;

endpackage

`default_nettype wire

// ===== sv/eio_div.sv =====
// ----------------------------------------------------------------------------
// eio_div
// Pipelined restoring divider, one quotient bit per stage, a < b on entry.
// ----------------------------------------------------------------------------
`default_nettype none

module eio_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire eio_pkg::eio_ctl_t             ctl_in,
  input  wire logic [eio_pkg::NUM_W-1:0]     a_in,
  input  wire logic [eio_pkg::NUM_W-1:0]     b_in,
  output eio_pkg::eio_ctl_t                  ctl_out,
  output logic [eio_pkg::Q_W-1:0]            q_out
);

  localparam int STEPS = eio_pkg::DIV_STEPS;
  localparam int NW    = eio_pkg::NUM_W;
  localparam int QW    = eio_pkg::Q_W;

  logic [NW:0]          rem [1:STEPS-1];
  logic [NW-1:0]        dvs [1:STEPS-1];
  logic [QW-1:0]        quo [1:STEPS];
  eio_pkg::eio_ctl_t    ctl [1:STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [NW:0]       r_src;
    logic [NW-1:0]     b_src;
    logic [QW-1:0]     q_src;
    eio_pkg::eio_ctl_t c_src;
    logic [NW:0]       sh;
    logic              ge;

    if (k == 0) begin : g_in
      assign r_src = {1'b0, a_in};
      assign b_src = b_in;
      assign q_src = '0;
      assign c_src = ctl_in;
    end else begin : g_mid
      assign r_src = rem[k];
      assign b_src = dvs[k];
      assign q_src = quo[k];
      assign c_src = ctl[k];
    end

    assign sh = {r_src[NW-1:0], 1'b0};
    assign ge = sh >= {1'b0, b_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1] <= '0;
      end else begin
        ctl[k+1] <= c_src;
      end
      quo[k+1] <= {q_src[QW-2:0], ge};
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? (sh - {1'b0, b_src}) : sh;
        dvs[k+1] <= b_src;
      end
    end
  end

  assign ctl_out = ctl[STEPS];
  assign q_out   = quo[STEPS];

endmodule

`default_nettype wire

// ===== sv/ease_in_out_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// ease_in_out_interpolator_unit
// Position on an ease-in / cruise / ease-out profile for a query time.
// ----------------------------------------------------------------------------
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+---------------------------
//  query    | start, busy, time_now                | taken on start & !busy
//  result   | done, position                       | one-cycle strobe
//  config   | cfg_valid, cfg_ready, cfg_index,     | write on valid & ready
//           | cfg_data                             |
//
// One item per cycle through 4 setup stages, 31 divider stages
// (one quotient bit each), 6 output stages (Hermite cubing, scale, round).
// Synchronous reset flushes every stage; busy and !cfg_ready during reset.
// Results cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ease_in_out_interpolator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [eio_pkg::TIME_W-1:0]        time_now,
  output logic                                   done,
  output logic signed [eio_pkg::VAL_W-1:0]       position,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [eio_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [eio_pkg::VAL_W-1:0]         cfg_data
);

  localparam int TW = eio_pkg::TIME_W;
  localparam int VW = eio_pkg::VAL_W;
  localparam int NW = eio_pkg::NUM_W;
  localparam int FW = eio_pkg::F_W;

  // configuration
  logic [TW-1:0] total_duration, ease_in_time, ease_out_time;
  logic [VW-1:0] start_value, end_value;

  assign busy      = rst;
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_duration <= '0;
      ease_in_time   <= '0;
      ease_out_time  <= '0;
      start_value    <= '0;
      end_value      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        eio_pkg::REG_TOTAL_DURATION: total_duration <= cfg_data[TW-1:0];
        eio_pkg::REG_EASE_IN_TIME:   ease_in_time   <= cfg_data[TW-1:0];
        eio_pkg::REG_EASE_OUT_TIME:  ease_out_time  <= cfg_data[TW-1:0];
        eio_pkg::REG_START_VALUE:    start_value    <= cfg_data;
        eio_pkg::REG_END_VALUE:      end_value      <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived terms: user keeps config static with items in flight (unenforced)
  logic signed [TW+1:0] t2, lim;
  logic signed [TW+2:0] nv;
  logic signed [VW:0]   dlt;
  logic [VW-1:0]        mag;
  logic                 v1, v2, v3;

  assign t2  = $signed({2'b00, total_duration}) - $signed({2'b00, ease_in_time})
               - $signed({2'b00, ease_out_time});
  assign nv  = $signed({2'b00, total_duration, 1'b0}) - $signed({3'b000, ease_in_time})
               - $signed({3'b000, ease_out_time});
  assign lim = $signed({2'b00, total_duration}) - $signed({2'b00, ease_out_time});
  assign dlt = $signed({end_value[VW-1], end_value}) - $signed({start_value[VW-1], start_value});
  assign mag = dlt[VW] ? VW'(-dlt) : dlt[VW-1:0];
  assign v1  = |ease_in_time;
  assign v2  = t2 != '0;
  assign v3  = |ease_out_time;

  // S0: clamp query time
  logic          s0_valid;
  logic [TW-1:0] s0_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_t <= (time_now > total_duration) ? total_duration : time_now;
  end

  // S1: segment choice and products
  logic signed [TW+1:0] t_s, tw, w, x1, y1, xd;
  logic signed [2*TW+3:0] m1_c, m2_c;
  logic signed [2*TW+4:0] md_c;
  eio_pkg::seg_t          seg_c;

  assign t_s = $signed({2'b00, s0_t});
  assign tw  = $signed({1'b0, s0_t, 1'b0}) - $signed({2'b00, ease_in_time});
  assign w   = t_s - lim;

  always_comb begin
    if (v1 && v2 && (s0_t <= ease_in_time)) begin
      seg_c = eio_pkg::SEG_ACCEL;
    end else if (v2 && (s0_t > ease_in_time) && (t_s <= lim)) begin
      seg_c = eio_pkg::SEG_CRUISE;
    end else if (v2 && v3) begin
      seg_c = (nv == '0) ? eio_pkg::SEG_HERM : eio_pkg::SEG_DECEL;
    end else begin
      seg_c = (total_duration == '0) ? eio_pkg::SEG_FULL : eio_pkg::SEG_LINEAR;
    end
  end

  assign x1   = (seg_c == eio_pkg::SEG_ACCEL) ? t_s : tw;
  assign y1   = (seg_c == eio_pkg::SEG_ACCEL) ? t_s : $signed({2'b00, ease_out_time});
  assign xd   = (seg_c == eio_pkg::SEG_ACCEL) ? $signed({2'b00, ease_in_time})
                                              : $signed({2'b00, ease_out_time});
  assign m1_c = x1 * y1;
  assign m2_c = w * w;
  assign md_c = xd * nv;

  logic                 s1_valid;
  eio_pkg::seg_t        s1_seg;
  logic [TW-1:0]        s1_t;
  logic signed [TW+1:0] s1_tw, s1_w;
  logic signed [NW-1:0] s1_m1, s1_m2, s1_md;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1_seg <= seg_c;
    s1_t   <= s0_t;
    s1_tw  <= tw;
    s1_w   <= w;
    s1_m1  <= m1_c;
    s1_m2  <= m2_c;
    s1_md  <= md_c[NW-1:0];
  end

  // S2: ratio numerator and denominator
  logic signed [NW-1:0] num_c, den_c;

  always_comb begin
    case (s1_seg)
      eio_pkg::SEG_ACCEL: begin
        num_c = s1_m1;
        den_c = s1_md;
      end
      eio_pkg::SEG_CRUISE: begin
        num_c = NW'(s1_tw);
        den_c = NW'(nv);
      end
      eio_pkg::SEG_DECEL: begin
        num_c = s1_m1 - s1_m2;
        den_c = s1_md;
      end
      eio_pkg::SEG_HERM: begin
        num_c = NW'(s1_w);
        den_c = $signed({{(NW-TW){1'b0}}, ease_out_time});
      end
      default: begin
        num_c = $signed({{(NW-TW){1'b0}}, s1_t});
        den_c = $signed({{(NW-TW){1'b0}}, total_duration});
      end
    endcase
  end

  logic                 s2_valid, s2_herm, s2_full;
  logic signed [NW-1:0] s2_num, s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_herm <= s1_seg == eio_pkg::SEG_HERM;
    s2_full <= s1_seg == eio_pkg::SEG_FULL;
    s2_num  <= num_c;
    s2_den  <= den_c;
  end

  // S3: sign checks and magnitudes
  logic              s3_valid, s3_herm, s3_full, s3_zero;
  logic [NW-1:0]     s3_a, s3_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_herm <= s2_herm;
    s3_full <= s2_full;
    s3_zero <= !s2_full && ((s2_den == '0) || (s2_num == '0) ||
                            (s2_num[NW-1] != s2_den[NW-1]));
    s3_a    <= s2_num[NW-1] ? NW'(-s2_num) : s2_num;
    s3_b    <= s2_den[NW-1] ? NW'(-s2_den) : s2_den;
  end

  eio_pkg::eio_ctl_t          div_ctl_in, div_ctl_out;
  logic [eio_pkg::Q_W-1:0]    div_q;

  always_comb begin
    div_ctl_in.valid = s3_valid;
    div_ctl_in.zero  = s3_zero;
    div_ctl_in.one   = s3_full || (s3_a >= s3_b);
    div_ctl_in.herm  = s3_herm;
  end

  eio_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (div_ctl_in),
    .a_in    (s3_a),
    .b_in    (s3_b),
    .ctl_out (div_ctl_out),
    .q_out   (div_q)
  );

  // P0: round quotient to Q1.30
  logic          p0_valid, p0_herm;
  logic [FW-1:0] p0_f;
  logic [FW:0]   q_inc;

  assign q_inc = {1'b0, div_q} + (FW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= div_ctl_out.valid;
    end
    p0_herm <= div_ctl_out.herm;
    if (div_ctl_out.zero) begin
      p0_f <= '0;
    end else if (div_ctl_out.one) begin
      p0_f <= eio_pkg::ONE30;
    end else begin
      p0_f <= q_inc[FW:1];
    end
  end

  // P1/P2: u^2 and u^3 for the plain Hermite ease
  logic [2*FW-1:0] sq_c, cube_c;
  logic            p1_valid, p1_herm, p2_valid, p2_herm;
  logic [FW-1:0]   p1_f, p1_u2, p2_f, p2_u2, p2_u3;

  assign sq_c = p0_f * p0_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= p0_valid;
    end
    p1_herm <= p0_herm;
    p1_f    <= p0_f;
    p1_u2   <= sq_c[FW+29:30];
  end

  assign cube_c = p1_u2 * p1_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_herm <= p1_herm;
    p2_f    <= p1_f;
    p2_u2   <= p1_u2;
    p2_u3   <= cube_c[FW+29:30];
  end

  // P3: 3u^2 - 2u^3, clamp to [0, 1]
  logic signed [FW+1:0] fh;
  logic [FW-1:0]        fh_clamp;
  logic                 p3_valid;
  logic [FW-1:0]        p3_f;

  assign fh = $signed({1'b0, p2_u2, 1'b0}) + $signed({2'b00, p2_u2})
              - $signed({1'b0, p2_u3, 1'b0});

  always_comb begin
    if (fh[FW+1]) begin
      fh_clamp = '0;
    end else if (fh > $signed({2'b00, eio_pkg::ONE30})) begin
      fh_clamp = eio_pkg::ONE30;
    end else begin
      fh_clamp = fh[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_f <= p2_herm ? fh_clamp : p2_f;
  end

  // P4: scale span by fraction
  logic             p4_valid;
  logic [VW+FW-1:0] p4_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
    p4_prod <= mag * p3_f;
  end

  // P5: round and offset from start
  logic [VW+FW:0] rnd_sum;
  logic [VW-1:0]  step;

  assign rnd_sum = {1'b0, p4_prod} + ((VW+FW+1)'(1) << 29);
  assign step    = rnd_sum[VW+29:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p4_valid;
    end
    position <= dlt[VW] ? $signed(start_value - step) : $signed(start_value + step);
  end

endmodule

`default_nettype wire
